// File: hw/rtl/pett_pkg.sv
package pett_pkg;

    localparam int MaxEntries  = 16;
    localparam int HandleBits  = 8;
    localparam int PendingBits = 8;
    localparam int IdxBits     = $clog2(MaxEntries);
    localparam int CntBits     = $clog2(MaxEntries + 1);

    localparam logic [1:0] ModeTick    = 2'd0;
    localparam logic [1:0] ModeAdd     = 2'd1;
    localparam logic [1:0] ModeRemove  = 2'd2;
    localparam logic [1:0] ModeService = 2'd3;

    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusFull     = 2'd1;
    localparam logic [1:0] StatusNotFound = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  handle;
        logic [31:0] period;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic        fired_valid;
        logic [7:0]  fired_handle;
        logic        last;
        logic [31:0] now_ms;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture the input word
        logic tick_inc;    // advance the tick counter
        logic add_do;      // append entry
        logic scan_begin;  // reset walk pointers
        logic div_start;   // start remainder for current entry
        logic tick_apply;  // apply remainder result to current entry
        logic rem_step;    // one compaction step
        logic srv_step;    // one service step
        logic rem_finish;  // commit compacted count
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;   // walk pointer reached entry count
        logic div_done;
        logic full;
        logic srv_hit;     // current entry has pending firings
    } t_sts;

endpackage

// File: hw/rtl/pett_div.sv
module pett_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic        o_zero
);
    // restoring remainder, one bit per cycle
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_num, n_num;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] shifted;
    logic [32:0] diff;

    always_comb begin
        shifted = {r_rem, r_num[31]};
        diff    = shifted - {1'b0, r_den};
        n_num   = {r_num[30:0], 1'b0};
        if (!diff[32]) begin
            n_rem = diff[31:0];
        end else begin
            n_rem = shifted[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_rem  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= n_num;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_zero = (r_rem == '0);
endmodule

// File: hw/rtl/pett_datapath.sv
module pett_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pett_pkg::t_in_word i_word,
    input  pett_pkg::t_ctl     i_ctl,
    output pett_pkg::t_sts     o_sts,
    output logic [1:0]         o_mode,
    output logic [7:0]         o_cur_handle,
    output logic               o_found,
    output logic [31:0]        o_now
);
    import pett_pkg::*;

    logic [HandleBits-1:0]  r_handle [MaxEntries];
    logic [31:0]            r_period [MaxEntries];
    logic [PendingBits-1:0] r_pend   [MaxEntries];
    logic [CntBits-1:0]     r_count;
    logic [CntBits-1:0]     r_rd, r_wr;
    logic [31:0]            r_now;
    t_in_word               r_in;
    logic                   r_found;
    logic [IdxBits-1:0]     rd_idx, wr_idx;
    logic                   div_done, div_zero;
    logic [HandleBits-1:0]  in_h;

    assign rd_idx = r_rd[IdxBits-1:0];
    assign wr_idx = r_wr[IdxBits-1:0];
    assign in_h   = r_in.handle[HandleBits-1:0];

    pett_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (r_now),
        .i_den   (r_period[rd_idx]),
        .o_done  (div_done),
        .o_zero  (div_zero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_now   <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_ctl.load) r_in <= i_word;
            if (i_ctl.tick_inc) r_now <= r_now + 32'd1;
            if (i_ctl.scan_begin) begin
                r_rd    <= '0;
                r_wr    <= '0;
                r_found <= 1'b0;
            end
            if (i_ctl.add_do) begin
                r_handle[r_count[IdxBits-1:0]] <= in_h;
                r_period[r_count[IdxBits-1:0]] <= r_in.period;
                r_pend[r_count[IdxBits-1:0]]   <= '0;
                r_count <= r_count + 1'b1;
            end
            if (i_ctl.tick_apply) begin
                if (r_period[rd_idx] != '0 && div_zero && r_pend[rd_idx] != '1) begin
                    r_pend[rd_idx] <= r_pend[rd_idx] + 1'b1;
                end
                r_rd <= r_rd + 1'b1;
            end
            if (i_ctl.rem_step) begin
                if (r_handle[rd_idx] == in_h) begin
                    r_found <= 1'b1;
                end else begin
                    r_handle[wr_idx] <= r_handle[rd_idx];
                    r_period[wr_idx] <= r_period[rd_idx];
                    r_pend[wr_idx]   <= r_pend[rd_idx];
                    r_wr <= r_wr + 1'b1;
                end
                r_rd <= r_rd + 1'b1;
            end
            if (i_ctl.rem_finish) r_count <= r_wr;
            if (i_ctl.srv_step) begin
                if (r_pend[rd_idx] != '0) r_pend[rd_idx] <= r_pend[rd_idx] - 1'b1;
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    assign o_sts.scan_done = (r_rd >= r_count);
    assign o_sts.div_done  = div_done;
    assign o_sts.full      = (r_count >= CntBits'(MaxEntries));
    assign o_sts.srv_hit   = (r_rd < r_count) && (r_pend[rd_idx] != '0);
    assign o_mode          = r_in.mode;
    assign o_cur_handle    = 8'(r_handle[rd_idx]);
    assign o_found         = r_found;
    assign o_now           = r_now;
endmodule

// File: hw/rtl/pett_ctrl.sv
module pett_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pett_pkg::t_sts     i_sts,
    input  logic [1:0]         i_mode,
    input  logic [7:0]         i_cur_handle,
    input  logic               i_found,
    input  logic [31:0]        i_now,
    output pett_pkg::t_ctl     o_ctl,
    output logic               o_busy,
    output logic               o_done,
    output pett_pkg::t_out_word o_result
);
    import pett_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StDisp = 3'd1;
    localparam logic [2:0] StTick = 3'd2;
    localparam logic [2:0] StWait = 3'd3;
    localparam logic [2:0] StRem  = 3'd4;
    localparam logic [2:0] StSrv  = 3'd5;
    localparam logic [2:0] StEnd  = 3'd6;

    logic [2:0] r_state, n_state;
    // one-deep hold for the service output so last can be set on the final hit
    logic       r_hold_v;
    logic [7:0] r_hold_h;
    // table full as seen before the add, the count has moved on by the end state
    logic       r_add_full;
    logic [1:0] status_sel;
    logic       emit_hold, emit_final;
    logic       r_done;
    t_out_word  r_res;

    always_comb begin
        o_ctl      = '0;
        n_state    = r_state;
        emit_hold  = 1'b0;
        emit_final = 1'b0;
        unique case (r_state)
            StIdle: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = StDisp;
                end
            end
            StDisp: begin
                o_ctl.scan_begin = 1'b1;
                unique case (i_mode)
                    ModeTick: begin
                        o_ctl.tick_inc = 1'b1;
                        n_state = StTick;
                    end
                    ModeAdd: begin
                        o_ctl.add_do = !i_sts.full;
                        n_state = StEnd;
                    end
                    ModeRemove:  n_state = StRem;
                    ModeService: n_state = StSrv;
                    default:     n_state = StEnd;
                endcase
            end
            StTick: begin
                if (i_sts.scan_done) begin
                    n_state = StEnd;
                end else begin
                    o_ctl.div_start = 1'b1;
                    n_state = StWait;
                end
            end
            StWait: begin
                if (i_sts.div_done) begin
                    o_ctl.tick_apply = 1'b1;
                    n_state = StTick;
                end
            end
            StRem: begin
                if (i_sts.scan_done) begin
                    o_ctl.rem_finish = 1'b1;
                    n_state = StEnd;
                end else begin
                    o_ctl.rem_step = 1'b1;
                end
            end
            StSrv: begin
                if (i_sts.scan_done) begin
                    emit_final = 1'b1;
                    n_state = StIdle;
                end else begin
                    o_ctl.srv_step = 1'b1;
                    emit_hold = i_sts.srv_hit && r_hold_v;
                end
            end
            StEnd: begin
                emit_final = 1'b1;
                n_state = StIdle;
            end
            default: n_state = StIdle;
        endcase
    end

    always_comb begin
        unique case (i_mode)
            ModeAdd:    status_sel = r_add_full ? StatusFull : StatusOk;
            ModeRemove: status_sel = i_found ? StatusOk : StatusNotFound;
            default:    status_sel = StatusOk;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= StIdle;
            r_done     <= 1'b0;
            r_hold_v   <= 1'b0;
            r_add_full <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= emit_hold || emit_final;
            if (r_state == StDisp) begin
                r_hold_v   <= 1'b0;
                r_add_full <= i_sts.full;
            end
            if (o_ctl.srv_step && i_sts.srv_hit) begin
                r_hold_v <= 1'b1;
                r_hold_h <= i_cur_handle;
            end
            if (emit_final) r_hold_v <= 1'b0;
        end
        r_res.now_ms <= i_now;
        r_res.last   <= emit_final;
        if (emit_hold) begin
            r_res.status       <= StatusOk;
            r_res.fired_valid  <= 1'b1;
            r_res.fired_handle <= r_hold_h;
        end else if (r_state == StSrv) begin
            r_res.status       <= StatusOk;
            r_res.fired_valid  <= r_hold_v;
            r_res.fired_handle <= r_hold_v ? r_hold_h : 8'd0;
        end else begin
            r_res.status       <= status_sel;
            r_res.fired_valid  <= 1'b0;
            r_res.fired_handle <= 8'd0;
        end
    end

    assign o_busy   = (r_state != StIdle);
    assign o_done   = r_done;
    assign o_result = r_res;

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == StSrv || $past(r_state) == StEnd)
        else $error("result strobe outside a result state");
    a_start_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StIdle && i_start) |=> r_state == StDisp)
        else $error("accepted word not dispatched");
    a_step_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctl.tick_apply, o_ctl.rem_step, o_ctl.srv_step, o_ctl.add_do}))
        else $error("conflicting table commands");
endmodule

// File: hw/rtl/periodic_event_table_timer.sv
// sequence to the last result: tick walks every table entry through the
// bit-serial remainder (issue, 32 bit steps, done), add appends one entry,
// remove and service walk the table one entry at a time
// throughput: one word at a time, busy high from acceptance until the last result
// results are strobed by o_done for one cycle each; the receiver cannot stall
// reset: synchronous active low, clears tick counter and entry count
module periodic_event_table_timer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pett_pkg::t_in_word    i_word,
    output logic                  o_done,
    output pett_pkg::t_out_word   o_result
);
    import pett_pkg::*;

    // command and status between controller and datapath
    t_ctl        ctl;
    t_sts        sts;
    logic [1:0]  mode;
    logic [7:0]  cur_handle;
    logic        found;
    logic [31:0] now;

    // table storage, tick counter and shared remainder unit
    pett_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word       (i_word),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .o_mode       (mode),
        .o_cur_handle (cur_handle),
        .o_found      (found),
        .o_now        (now)
    );

    // sequencer walks the table one entry at a time
    pett_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_sts        (sts),
        .i_mode       (mode),
        .i_cur_handle (cur_handle),
        .i_found      (found),
        .i_now        (now),
        .o_ctl        (ctl),
        .o_busy       (busy),
        .o_done       (o_done),
        .o_result     (o_result)
    );
endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pett_pkg::*;

    localparam int CycleLimit = 2000000;
    localparam logic [PendingBits-1:0] PendingMax = '1;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in_word i_word;
    logic o_done;
    t_out_word o_result;

    periodic_event_table_timer uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_word   (i_word),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // timer table mirror
    logic [31:0]            ms_count;
    int                     slot_count;
    logic [HandleBits-1:0]  slot_handle [MaxEntries];
    logic [31:0]            slot_period [MaxEntries];
    logic [PendingBits-1:0] slot_pending [MaxEntries];

    t_in_word  word_queue[$];      // words waiting for the driver
    t_out_word expected_words[$];  // results still to come
    int        gap_queue[$];       // idle cycles before each word
    int        fail_count = 0;
    int        cycle_count = 0;
    bit        stim_done = 0;
    bit        hold_off = 0;       // driver pause until the block drains

    function automatic t_out_word make_result(logic [1:0] st, logic vld,
                                              logic [7:0] hnd, logic lst);
        t_out_word r;
        r.status = st;
        r.fired_valid = vld;
        r.fired_handle = hnd;
        r.last = lst;
        r.now_ms = ms_count;
        return r;
    endfunction

    // advance the mirror for one accepted word and queue what it produces
    task automatic predict_word(t_in_word w);
        int wr;
        int hits;
        bit found;
        logic [1:0] st;
        wr = 0;
        hits = 0;
        found = 0;
        st = StatusOk;
        case (w.mode)
            ModeTick: begin
                ms_count = ms_count + 32'd1;
                for (int k = 0; k < slot_count; k++)
                    if (slot_period[k] != 0 && ms_count % slot_period[k] == 0
                        && slot_pending[k] != PendingMax)
                        slot_pending[k]++;
            end
            ModeAdd: begin
                if (slot_count >= MaxEntries) begin
                    st = StatusFull;
                end else begin
                    slot_handle[slot_count] = w.handle;
                    slot_period[slot_count] = w.period;
                    slot_pending[slot_count] = '0;
                    slot_count++;
                end
            end
            ModeRemove: begin
                for (int k = 0; k < slot_count; k++) begin
                    if (slot_handle[k] == w.handle) begin
                        found = 1;
                    end else begin
                        slot_handle[wr] = slot_handle[k];
                        slot_period[wr] = slot_period[k];
                        slot_pending[wr] = slot_pending[k];
                        wr++;
                    end
                end
                slot_count = wr;
                if (!found) st = StatusNotFound;
            end
            default: begin
                for (int k = 0; k < slot_count; k++) begin
                    if (slot_pending[k] != 0) begin
                        slot_pending[k]--;
                        expected_words.push_back(make_result(StatusOk, 1'b1,
                                                 slot_handle[k], 1'b0));
                        hits++;
                    end
                end
                // flag the final firing of this service pass
                if (hits > 0) expected_words[$].last = 1'b1;
            end
        endcase
        if (w.mode != ModeService || hits == 0)
            expected_words.push_back(make_result(st, 1'b0, 8'd0, 1'b1));
    endtask

    // driver: one word at a time, random gap before each
    int  gap_left = 0;
    bit  gap_loaded = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_loaded <= 1'b0;
        end else if (start && !busy) begin
            // word taken at this edge
            predict_word(i_word);
            start <= 1'b0;
            gap_loaded <= 1'b0;
        end else if (!start && word_queue.size() > 0
                     && !(hold_off && expected_words.size() > 0)) begin
            if (!gap_loaded) begin
                gap_left <= gap_queue.pop_front();
                gap_loaded <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else begin
                i_word <= word_queue.pop_front();
                start <= 1'b1;
            end
        end
    end

    // monitor: results cannot be stalled, check each strobed word
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_result);
                fail_count++;
            end else begin
                t_out_word e;
                e = expected_words.pop_front();
                if (e !== o_result) begin
                    $display("%0t: mismatch expected %p actual %p",
                             $time, e, o_result);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_word(logic [1:0] m, logic [7:0] h, logic [31:0] p);
        t_in_word w;
        w.mode = m;
        w.handle = h;
        w.period = p;
        word_queue.push_back(w);
        // mostly short gaps, sometimes none for long stretches
        gap_queue.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
    endtask

    // small handle pool so removes hit and duplicates happen
    function automatic logic [7:0] pick_handle();
        return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    initial begin
        int sim_rows;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_word = '0;
        ms_count = '0;
        slot_count = 0;
        for (int k = 0; k < MaxEntries; k++) begin
            slot_handle[k] = '0;
            slot_period[k] = '0;
            slot_pending[k] = '0;
        end

        // directed: empty service, not found, zero period, duplicates,
        // extreme fields, nearly full table
        queue_word(ModeService, 8'h00, 32'h0);
        queue_word(ModeRemove, 8'hFF, 32'hFFFF_FFFF);
        queue_word(ModeAdd, 8'hFF, 32'd1);
        queue_word(ModeAdd, 8'h00, 32'd0);
        queue_word(ModeAdd, 8'hAA, 32'hFFFF_FFFF);
        queue_word(ModeAdd, 8'hAA, 32'd2);
        queue_word(ModeAdd, 8'h55, 32'd2);
        queue_word(ModeTick, 8'hFF, 32'hFFFF_FFFF);
        queue_word(ModeTick, 8'h00, 32'h0);
        queue_word(ModeService, 8'hFF, 32'hFFFF_FFFF);
        queue_word(ModeRemove, 8'hAA, 32'd0);
        queue_word(ModeService, 8'h00, 32'd0);
        for (int k = 0; k < 12; k++) queue_word(ModeAdd, 8'(k), 32'd1);

        // saturate pending counts: the last free slot, then many ticks
        queue_word(ModeAdd, 8'h77, 32'd1);
        for (int n = 0; n < 260; n++) queue_word(ModeTick, 8'h00, 32'd0);
        queue_word(ModeService, 8'h00, 32'd0);

        // random: mix that keeps the table busy and firing
        for (int n = 0; n < 140; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_word(ModeTick, 8'($urandom), $urandom);
                4, 5:       queue_word(ModeAdd, pick_handle(), pick_period());
                6:          queue_word(ModeRemove, pick_handle(), $urandom);
                default:    queue_word(ModeService, 8'($urandom), $urandom);
            endcase
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pause the sender once until everything has drained
        wait (word_queue.size() < 100);
        @(posedge i_clk);
        hold_off <= 1'b1;
        wait (expected_words.size() == 0);
        @(posedge i_clk);
        hold_off <= 1'b0;

        wait (word_queue.size() == 0 && !start);
        wait (expected_words.size() == 0);
        sim_rows = 0;
        while (sim_rows < 600) begin
            @(posedge i_clk);
            sim_rows++;
        end
        stim_done = 1;
    end

    // end of run
    initial begin
        wait (stim_done || cycle_count >= CycleLimit);
        if (stim_done && fail_count == 0 && expected_words.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            if (!stim_done) $display("%0t: timeout", $time);
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
